// ===== sv/nbw_pkg.sv =====
// ----------------------------------------------------------------------------
// nbw_pkg
// shared types, constants and exp tables for the neighbor edge weight block
// ----------------------------------------------------------------------------
`default_nettype none
package nbw_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_BITS      = 12;
  localparam int PIX_BITS      = 3 * CHANNEL_BITS;
  localparam int D2_BITS       = 2 * CHANNEL_BITS + 2;
  localparam int TASK_DEPTH    = 2;
  localparam int WGT_BITS      = 24;
  localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BETA         = 2'd2,
    CFG_GAMMA        = 2'd3
  } cfg_index_t;

  // neighbour slots, also the back end's lane order
  typedef enum logic [1:0] {
    NB_LEFT    = 2'd0,
    NB_UPLEFT  = 2'd1,
    NB_UP      = 2'd2,
    NB_UPRIGHT = 2'd3
  } nb_lane_t;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } in_word_t;

  typedef struct packed {
    logic [23:0] left_weight;
    logic [23:0] upleft_weight;
    logic [23:0] up_weight;
    logic [23:0] upright_weight;
    logic        end_of_frame;
  } out_word_t;

  typedef logic [PIX_BITS-1:0] pixel_t;

  typedef struct packed {
    pixel_t            cur;
    pixel_t [3:0]      nbr;      // indexed by nb_lane_t
    logic   [3:0]      nb_ok;    // neighbour lies inside the image
    logic              eof;
  } task_t;

  function automatic pixel_t pack_pixel(in_word_t w);
    pack_pixel = {w.chan2[CHANNEL_BITS-1:0], w.chan1[CHANNEL_BITS-1:0],
                  w.chan0[CHANNEL_BITS-1:0]};
  endfunction

  function automatic logic [D2_BITS-1:0] dist2(pixel_t p, pixel_t q);
    logic [CHANNEL_BITS-1:0] a, b, d;
    logic [D2_BITS-1:0]      s;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      a = p[i*CHANNEL_BITS +: CHANNEL_BITS];
      b = q[i*CHANNEL_BITS +: CHANNEL_BITS];
      d = (a > b) ? a - b : b - a;
      s = s + D2_BITS'(d) * D2_BITS'(d);
    end
    dist2 = s;
  endfunction

  // exp(-n), UQ1.16
  function automatic logic [16:0] exp_int(logic [3:0] n);
    unique case (n)
      4'd0:    exp_int = 17'd65536;
      4'd1:    exp_int = 17'd24109;
      4'd2:    exp_int = 17'd8869;
      4'd3:    exp_int = 17'd3263;
      4'd4:    exp_int = 17'd1200;
      4'd5:    exp_int = 17'd442;
      4'd6:    exp_int = 17'd162;
      4'd7:    exp_int = 17'd60;
      4'd8:    exp_int = 17'd22;
      4'd9:    exp_int = 17'd8;
      4'd10:   exp_int = 17'd3;
      4'd11:   exp_int = 17'd1;
      default: exp_int = 17'd0;
    endcase
  endfunction

  // exp(-k/16), UQ1.16
  function automatic logic [16:0] exp_frac(logic [3:0] k);
    unique case (k)
      4'd0:  exp_frac = 17'd65536;
      4'd1:  exp_frac = 17'd61565;
      4'd2:  exp_frac = 17'd57835;
      4'd3:  exp_frac = 17'd54331;
      4'd4:  exp_frac = 17'd51039;
      4'd5:  exp_frac = 17'd47947;
      4'd6:  exp_frac = 17'd45042;
      4'd7:  exp_frac = 17'd42313;
      4'd8:  exp_frac = 17'd39750;
      4'd9:  exp_frac = 17'd37341;
      4'd10: exp_frac = 17'd35079;
      4'd11: exp_frac = 17'd32954;
      4'd12: exp_frac = 17'd30957;
      4'd13: exp_frac = 17'd29081;
      4'd14: exp_frac = 17'd27319;
      4'd15: exp_frac = 17'd25664;
      default: exp_frac = 17'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== sv/nbw_ram.sv =====
// ----------------------------------------------------------------------------
// nbw_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module nbw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/nbw_front.sv =====
// ----------------------------------------------------------------------------
// nbw_front
// raster position tracking, line store access and neighbour gathering
// ----------------------------------------------------------------------------
`default_nettype none
module nbw_front #(
  parameter int MAX_WIDTH = nbw_pkg::MAX_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire nbw_pkg::in_word_t in_data,
  input  wire logic [10:0]       image_width,
  input  wire logic [12:0]       image_height,
  output logic                   q_push,
  output nbw_pkg::task_t         q_task,
  input  wire logic              q_full
);
  import nbw_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CWP = CW + 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_RD0  = 3'b010,
    F_RD1  = 3'b100
  } fstate_t;

  fstate_t             state_r, state_nxt;
  pixel_t              cur_r, prev_r, upl_r, above_r;
  logic [CW-1:0]       col_r, colcnt_r, colcnt_nxt;
  logic [ROW_BITS-1:0] row_r, rowcnt_r, rowcnt_nxt;
  logic [CWP-1:0]      w_eff;
  logic [13:0]         h_eff;
  logic [CW-1:0]       col_now, raddr;
  logic [ROW_BITS-1:0] row_now;
  pixel_t              rdata;
  logic                accept, last_col, last_row;

  // clamped sizes
  always_comb begin
    if (image_width == 11'd0) begin
      w_eff = CWP'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = CWP'(MAX_WIDTH);
    end else begin
      w_eff = CWP'(image_width);
    end
    if (image_height == 13'd0) begin
      h_eff = 14'd1;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = 14'(MAX_HEIGHT);
    end else begin
      h_eff = 14'(image_height);
    end
  end

  assign col_now = (32'(colcnt_r) >= 32'(w_eff)) ? CW'(w_eff - CWP'(1)) : colcnt_r;
  assign row_now = (32'(rowcnt_r) >= 32'(h_eff)) ? ROW_BITS'(h_eff - 14'd1) : rowcnt_r;

  assign in_full  = (state_r != F_IDLE);
  assign accept   = in_push && (state_r == F_IDLE);
  assign q_push   = (state_r == F_RD1) && !q_full;
  assign raddr    = (state_r == F_IDLE) ? col_now : CW'(32'(col_r) + 1);
  assign last_col = (32'(col_r) + 1 == 32'(w_eff));
  assign last_row = (32'(row_r) + 1 == 32'(h_eff));

  nbw_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (q_push),
    .waddr (col_r),
    .wdata (cur_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    q_task                  = '0;
    q_task.cur              = cur_r;
    q_task.nbr[NB_LEFT]     = prev_r;
    q_task.nbr[NB_UPLEFT]   = upl_r;
    q_task.nbr[NB_UP]       = above_r;
    q_task.nbr[NB_UPRIGHT]  = rdata;
    q_task.nb_ok[NB_LEFT]   = (col_r != '0);
    q_task.nb_ok[NB_UPLEFT] = (col_r != '0) && (row_r != '0);
    q_task.nb_ok[NB_UP]     = (row_r != '0);
    q_task.nb_ok[NB_UPRIGHT] = (row_r != '0) && (32'(col_r) + 1 < 32'(w_eff));
    q_task.eof              = last_col && last_row;
  end

  always_comb begin
    state_nxt  = state_r;
    colcnt_nxt = colcnt_r;
    rowcnt_nxt = rowcnt_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_RD0;
      F_RD0:  state_nxt = F_RD1;
      F_RD1: begin
        if (q_push) begin
          state_nxt = F_IDLE;
          if (last_col) begin
            colcnt_nxt = '0;
            rowcnt_nxt = last_row ? '0 : row_r + ROW_BITS'(1);
          end else begin
            colcnt_nxt = col_r + CW'(1);
            rowcnt_nxt = row_r;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      colcnt_r <= '0;
      rowcnt_r <= '0;
      prev_r   <= '0;
      upl_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      colcnt_r <= colcnt_nxt;
      rowcnt_r <= rowcnt_nxt;
      if (q_push) begin
        prev_r <= cur_r;
        upl_r  <= above_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r <= pack_pixel(in_data);
      col_r <= col_now;
      row_r <= row_now;
    end
    if (state_r == F_RD0) begin
      above_r <= rdata;
    end
  end
endmodule
`default_nettype wire

// ===== sv/nbw_queue.sv =====
// ----------------------------------------------------------------------------
// nbw_queue
// short task queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module nbw_queue #(
  parameter int DEPTH = nbw_pkg::TASK_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire nbw_pkg::task_t  wdata,
  output logic                 full,
  input  wire logic            pop,
  output nbw_pkg::task_t       rdata,
  output logic                 empty
);
  import nbw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  task_t          slot_r [DEPTH];
  logic [PW-1:0]  wptr_r, rptr_r;
  logic [NW-1:0]  cnt_r;

  assign full  = (32'(cnt_r) == DEPTH);
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push && !full) begin
        wptr_r <= (32'(wptr_r) == DEPTH - 1) ? '0 : wptr_r + PW'(1);
      end
      if (pop && !empty) begin
        rptr_r <= (32'(rptr_r) == DEPTH - 1) ? '0 : rptr_r + PW'(1);
      end
      cnt_r <= cnt_r + NW'(push && !full) - NW'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wptr_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

// ===== sv/nbw_back.sv =====
// ----------------------------------------------------------------------------
// nbw_back
// shared exp datapath, four neighbour weights in turn, output register
// ----------------------------------------------------------------------------
`default_nettype none
module nbw_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire nbw_pkg::task_t q_task,
  input  wire logic [23:0]    beta_q24,
  input  wire logic [15:0]    gamma_q8,
  output logic                out_empty,
  input  wire logic           out_pop,
  output nbw_pkg::out_word_t  out_data
);
  import nbw_pkg::*;

  localparam int AB = 24 + D2_BITS;

  typedef enum logic [7:0] {
    B_IDLE = 8'b0000_0001,
    B_D2   = 8'b0000_0010,
    B_A    = 8'b0000_0100,
    B_E1   = 8'b0000_1000,
    B_P    = 8'b0001_0000,
    B_E    = 8'b0010_0000,
    B_G    = 8'b0100_0000,
    B_W    = 8'b1000_0000
  } bstate_t;

  bstate_t              state_r, state_nxt;
  task_t                task_r;
  nb_lane_t             lane_r;
  logic [D2_BITS-1:0]   d2_r;
  logic [AB-1:0]        a_r;
  logic                 sat_r;
  logic [19:0]          r_r;
  logic [16:0]          e1_r, e_r;
  logic [39:0]          rr_r;
  logic [24:0]          p_r;
  logic [32:0]          g_r;
  logic [WGT_BITS-1:0]  wgt_r [3];
  out_word_t            out_r;
  logic                 out_valid_r;
  logic [WGT_BITS-1:0]  wgt_now;
  logic [33:0]          e1_prod;
  logic [41:0]          e_prod;
  logic [33:0]          str_sum;
  logic [48:0]          dia_sum;
  logic                 is_diag, out_free, load_out;

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_pop;
  assign load_out  = (state_r == B_W) && (lane_r == NB_UPRIGHT) && out_free;

  assign is_diag = (lane_r == NB_UPLEFT) || (lane_r == NB_UPRIGHT);
  assign e1_prod = 34'(exp_int(a_r[27:24])) * 34'(exp_frac(a_r[23:20])) + 34'd32768;
  assign e_prod  = 42'(e1_r) * 42'(p_r) + 42'd8388608;
  assign str_sum = 34'(g_r) + 34'd128;
  assign dia_sum = 49'(g_r) * 49'(INV_SQRT2_Q16) + 49'd8388608;

  always_comb begin
    if (!task_r.nb_ok[lane_r]) begin
      wgt_now = '0;
    end else if (is_diag) begin
      wgt_now = dia_sum[47:24];
    end else begin
      wgt_now = str_sum[31:8];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (q_pop) state_nxt = B_D2;
      B_D2:   state_nxt = B_A;
      B_A:    state_nxt = B_E1;
      B_E1:   state_nxt = B_P;
      B_P:    state_nxt = B_E;
      B_E:    state_nxt = B_G;
      B_G:    state_nxt = B_W;
      B_W: begin
        if (lane_r != NB_UPRIGHT) begin
          state_nxt = B_D2;
        end else if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      lane_r      <= NB_LEFT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        lane_r <= NB_LEFT;
      end else if ((state_r == B_W) && (lane_r != NB_UPRIGHT)) begin
        lane_r <= nb_lane_t'(lane_r + 2'd1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath, one step per state
  always_ff @(posedge clk) begin
    if (q_pop) begin
      task_r <= q_task;
    end
    if (state_r == B_D2) begin
      d2_r <= dist2(task_r.cur, task_r.nbr[lane_r]);
    end
    if (state_r == B_A) begin
      a_r <= AB'(beta_q24) * AB'(d2_r);
    end
    if (state_r == B_E1) begin
      sat_r <= (a_r[AB-1:24] >= (AB-24)'(12));
      e1_r  <= e1_prod[32:16];
      rr_r  <= 40'(a_r[19:0]) * 40'(a_r[19:0]);
      r_r   <= a_r[19:0];
    end
    if (state_r == B_P) begin
      p_r <= 25'h100_0000 - 25'(r_r) + 25'(rr_r[39:25]);
    end
    if (state_r == B_E) begin
      e_r <= sat_r ? 17'd0 : e_prod[40:24];
    end
    if (state_r == B_G) begin
      g_r <= 33'(gamma_q8) * 33'(e_r);
    end
    if ((state_r == B_W) && (lane_r != NB_UPRIGHT)) begin
      wgt_r[lane_r] <= wgt_now;
    end
    if (load_out) begin
      out_r.left_weight    <= wgt_r[NB_LEFT];
      out_r.upleft_weight  <= wgt_r[NB_UPLEFT];
      out_r.up_weight      <= wgt_r[NB_UP];
      out_r.upright_weight <= wgt_now;
      out_r.end_of_frame   <= task_r.eof;
    end
  end
endmodule
`default_nettype wire

// ===== sv/neighbor_edge_weights.sv =====
// ----------------------------------------------------------------------------
// neighbor_edge_weights
// four smoothness weights per pixel of a raster stream, top level
// ----------------------------------------------------------------------------
// the back end's single exp datapath sets the pace: it works one task at a time, in seven
//   steps for each of the four neighbours after its idle state loads the task
// reset: rst_n synchronous; counters, pixel history and registers go to defaults
//   (width 640, height 480, beta 0, gamma 12800); the line store is not cleared
//   and needs no clearing pass, data read from unwritten entries is masked by nb_ok
`default_nettype none
module neighbor_edge_weights #(
  parameter int MAX_WIDTH = nbw_pkg::MAX_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // pixel words in
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire nbw_pkg::in_word_t  in_data,
  // weight words out
  output logic                    out_empty,
  input  wire logic               out_pop,
  output nbw_pkg::out_word_t      out_data,
  // register writes
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import nbw_pkg::*;

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [23:0] beta_r;
  logic [15:0] gamma_r;

  task_t q_in, q_out;
  logic  q_push, q_full, q_pop, q_empty;

  // config registers; the user must write them only while the block is idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
      beta_r   <= 24'd0;
      gamma_r  <= 16'd12800;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[12:0];
        CFG_BETA:         beta_r   <= cfg_data;
        CFG_GAMMA:        gamma_r  <= cfg_data[15:0];
        default:          ;
      endcase
    end
  end

  // front: position, line store, neighbour gather; takes a new word only once the last is queued
  nbw_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data      (in_data),
    .image_width  (width_r),
    .image_height (height_r),
    .q_push       (q_push),
    .q_task       (q_in),
    .q_full       (q_full)
  );

  // task queue decouples the gather from the weight math
  nbw_queue #(.DEPTH(TASK_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_out),
    .empty (q_empty)
  );

  // back: exp and gain per neighbour, output register
  nbw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_task    (q_out),
    .beta_q24  (beta_r),
    .gamma_q8  (gamma_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("task queue overflow");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("task queue underflow");

  // an accepted pixel keeps the front busy in the next cycle
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full) else $error("front took two words back to back");
`endif
endmodule
`default_nettype wire
